[rtl/mer_pkg.sv]
// Shared types and constants of the midpoint ellipse rasterizer.
`default_nettype none

package mer_pkg;

	// Default sizes of the walk.
	localparam int AXIS_BITS_DEF     = 11;
	localparam int DECISION_BITS_DEF = 48;

	// Fixed field widths of the ports.
	localparam int CENTER_W    = 12;
	localparam int AXIS_REG_W  = 11;
	localparam int POINT_W     = 13;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 12;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SEMI_AXIS_X = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SEMI_AXIS_Y = 3'd3;

	// Reset values of the configuration registers.
	localparam logic signed [CENTER_W-1:0] CENTER_X_RST    = 12'sd1;
	localparam logic signed [CENTER_W-1:0] CENTER_Y_RST    = 12'sd2;
	localparam logic [AXIS_REG_W-1:0]      SEMI_AXIS_X_RST = 11'd6;
	localparam logic [AXIS_REG_W-1:0]      SEMI_AXIS_Y_RST = 11'd5;

	// Depth of the command queue; must be a power of two.
	localparam int QUEUE_DEPTH = 2;

	typedef logic op_t;
	localparam op_t OP_STEP    = 1'b0;
	localparam op_t OP_RESTART = 1'b1;

	typedef struct packed {
		logic signed [CENTER_W-1:0] center_x;
		logic signed [CENTER_W-1:0] center_y;
		logic [AXIS_REG_W-1:0]      semi_axis_x;
		logic [AXIS_REG_W-1:0]      semi_axis_y;
	} cfg_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} op_beat_t;

endpackage

`default_nettype wire

[rtl/mer_ifs.sv]
// Handshake channel interfaces for commands in and points out.
`default_nettype none

interface mer_cmd_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface mer_pix_if;
	logic                                valid;
	logic                                ready;
	logic signed [mer_pkg::POINT_W-1:0]  point_x;
	logic signed [mer_pkg::POINT_W-1:0]  point_y;
	logic                                last_of_step;
	logic                                ellipse_done;

	modport source (output valid, output point_x, output point_y, output last_of_step,
		output ellipse_done, input ready);
	modport sink (input valid, input point_x, input point_y, input last_of_step,
		input ellipse_done, output ready);
endinterface

`default_nettype wire

[rtl/mer_front.sv]
// Front end: takes command beats into a holding register and classifies them.
`default_nettype none

module mer_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	mer_cmd_if.sink                cmd,
	output mer_pkg::op_beat_t      push,
	input  wire logic              push_ready
);

	logic           hold_valid_q;
	mer_pkg::op_t   hold_op_q;
	logic           accept;

	assign cmd.ready  = !hold_valid_q || push_ready;
	assign accept     = cmd.valid && cmd.ready;
	assign push.valid = hold_valid_q;
	assign push.op    = hold_op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (accept) begin
			hold_valid_q <= 1'b1;
		end else if (push_ready) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_op_q <= cmd.restart ? mer_pkg::OP_RESTART : mer_pkg::OP_STEP;
		end
	end

endmodule

`default_nettype wire

[rtl/mer_queue.sv]
// Short command queue between the front end and the walk engine.
`default_nettype none

module mer_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mer_pkg::op_beat_t push,
	output logic                   push_ready,
	output mer_pkg::op_beat_t      head,
	input  wire logic              pop
);

	localparam int DEPTH = mer_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mer_pkg::op_t       entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.op    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.op;
		end
	end

endmodule

`default_nettype wire

[rtl/mer_back.sv]
// Walk engine: holds the ellipse state, runs the shared multiplier and emits points.
`default_nettype none

module mer_back #(
	parameter int AXIS_BITS     = mer_pkg::AXIS_BITS_DEF,
	parameter int DECISION_BITS = mer_pkg::DECISION_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mer_pkg::cfg_t     cfg,
	input  wire logic              axis_wr,
	input  wire mer_pkg::op_beat_t head,
	output logic                   pop,
	mer_pix_if.source              pix
);

	localparam int CW    = AXIS_BITS + 1;
	localparam int YW    = AXIS_BITS + 2;
	localparam int DW    = DECISION_BITS;
	localparam int MW    = DW + YW;
	localparam int PW    = mer_pkg::POINT_W;
	localparam int EXT_W = (PW > CW) ? PW : CW;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQA  = 4'd1;
	localparam logic [3:0] ST_SQB  = 4'd2;
	localparam logic [3:0] ST_SQC  = 4'd3;
	localparam logic [3:0] ST_RS1  = 4'd4;
	localparam logic [3:0] ST_RS2  = 4'd5;
	localparam logic [3:0] ST_Z1   = 4'd6;
	localparam logic [3:0] ST_Z2   = 4'd7;
	localparam logic [3:0] ST_Z3   = 4'd8;
	localparam logic [3:0] ST_Z4   = 4'd9;
	localparam logic [3:0] ST_Z5   = 4'd10;
	localparam logic [3:0] ST_Z6   = 4'd11;
	localparam logic [3:0] ST_Z7   = 4'd12;
	localparam logic [3:0] ST_EMIT = 4'd13;

	localparam logic [1:0] RG_DONE = 2'd0;
	localparam logic [1:0] RG_ONE  = 2'd1;
	localparam logic [1:0] RG_TWO  = 2'd2;

	logic [3:0]              state_q;
	logic                    stale_q;
	logic [1:0]              region_q;
	logic [1:0]              beat_q;
	logic signed [CW-1:0]    cur_x_q;
	logic signed [CW-1:0]    cur_y_q;
	logic signed [CW-1:0]    ex_q;
	logic signed [CW-1:0]    ey_q;
	logic signed [DW-1:0]    dec_q;
	logic signed [DW-1:0]    gx_q;
	logic signed [DW-1:0]    gy_q;
	logic signed [DW-1:0]    a2_q;
	logic signed [DW-1:0]    b2_q;
	logic signed [DW-1:0]    prod_q;

	logic [AXIS_BITS-1:0]    a_w;
	logic [AXIS_BITS-1:0]    b_w;
	logic signed [YW-1:0]    a_yw;
	logic signed [YW-1:0]    b_yw;
	logic signed [YW-1:0]    tx;
	logic signed [YW-1:0]    ty;
	logic signed [DW-1:0]    mul_x;
	logic signed [YW-1:0]    mul_y;
	logic signed [MW-1:0]    mul_full;

	logic                    reg_one;
	logic                    dec_neg;
	logic                    dec_pos;
	logic                    incx;
	logic                    decy;
	logic signed [CW-1:0]    cur_x_nx;
	logic signed [CW-1:0]    cur_y_nx;
	logic signed [DW-1:0]    gx_nx;
	logic signed [DW-1:0]    gy_nx;
	logic signed [DW-1:0]    dec_nx;
	logic signed [DW-1:0]    gy_rs;
	logic                    rs_in_one;
	logic                    leave_one;
	logic                    y_neg;
	logic                    step_go;
	logic                    beat_done;

	logic signed [EXT_W-1:0] ex_ext;
	logic signed [EXT_W-1:0] ey_ext;
	logic signed [EXT_W-1:0] cx_ext;
	logic signed [EXT_W-1:0] cy_ext;
	logic signed [EXT_W-1:0] px_full;
	logic signed [EXT_W-1:0] py_full;

	assign a_w  = AXIS_BITS'(cfg.semi_axis_x);
	assign b_w  = AXIS_BITS'(cfg.semi_axis_y);
	assign a_yw = YW'(a_w);
	assign b_yw = YW'(b_w);
	assign tx   = {cur_x_q, 1'b1};
	assign ty   = YW'(cur_y_q) - YW'(1);

	// One shared multiplier; only the low decision bits of the product are kept.
	always_comb begin
		case (state_q)
			ST_SQA: begin
				mul_x = DW'(a_w);
				mul_y = a_yw;
			end
			ST_SQB: begin
				mul_x = DW'(b_w);
				mul_y = b_yw;
			end
			ST_Z1: begin
				mul_x = b2_q;
				mul_y = tx;
			end
			ST_Z2: begin
				mul_x = prod_q;
				mul_y = tx;
			end
			ST_Z3: begin
				mul_x = a2_q;
				mul_y = ty;
			end
			ST_Z4: begin
				mul_x = prod_q;
				mul_y = ty;
			end
			ST_Z6: begin
				mul_x = prod_q;
				mul_y = b_yw;
			end
			default: begin
				mul_x = a2_q;
				mul_y = b_yw;
			end
		endcase
	end

	assign mul_full = MW'(mul_x) * MW'(mul_y);

	// Next step of the walk, taken from the state before the step.
	assign reg_one  = (region_q == RG_ONE);
	assign dec_neg  = dec_q[DW-1];
	assign dec_pos  = !dec_neg && (dec_q != '0);
	assign incx     = reg_one || !dec_pos;
	assign decy     = !reg_one || !dec_neg;
	assign cur_x_nx = incx ? cur_x_q + CW'(1) : cur_x_q;
	assign cur_y_nx = decy ? cur_y_q - CW'(1) : cur_y_q;
	assign gx_nx    = incx ? gx_q + (b2_q <<< 1) : gx_q;
	assign gy_nx    = decy ? gy_q - (a2_q <<< 1) : gy_q;
	assign dec_nx   = dec_q + (incx ? (gx_nx <<< 2) : '0) - (decy ? (gy_nx <<< 2) : '0)
		+ (reg_one ? (b2_q <<< 2) : (a2_q <<< 2));

	assign gy_rs     = prod_q <<< 1;
	assign rs_in_one = !gy_rs[DW-1] && (gy_rs != '0);
	assign leave_one = reg_one && !(gx_q < gy_q);
	assign y_neg     = cur_y_q[CW-1];

	assign pop       = (state_q == ST_IDLE) && !stale_q && head.valid;
	assign step_go   = pop && (head.op == mer_pkg::OP_STEP) && (region_q != RG_DONE);
	assign beat_done = (state_q == ST_EMIT) && pix.ready;

	// Mirror points: beat bit 0 flips x, beat bit 1 flips y.
	assign ex_ext  = EXT_W'(ex_q);
	assign ey_ext  = EXT_W'(ey_q);
	assign cx_ext  = EXT_W'(cfg.center_x);
	assign cy_ext  = EXT_W'(cfg.center_y);
	assign px_full = cx_ext + (beat_q[0] ? -ex_ext : ex_ext);
	assign py_full = cy_ext + (beat_q[1] ? -ey_ext : ey_ext);

	assign pix.valid        = (state_q == ST_EMIT);
	assign pix.point_x      = px_full[PW-1:0];
	assign pix.point_y      = py_full[PW-1:0];
	assign pix.last_of_step = (beat_q == 2'd3);
	assign pix.ellipse_done = y_neg && ((region_q == RG_TWO) || leave_one);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			stale_q  <= 1'b1;
			region_q <= RG_DONE;
			beat_q   <= '0;
			cur_x_q  <= '0;
			cur_y_q  <= '1;
			dec_q    <= '0;
			gx_q     <= '0;
			gy_q     <= '0;
		end else begin
			if (axis_wr) begin
				stale_q <= 1'b1;
			end else if ((state_q == ST_IDLE) && stale_q) begin
				stale_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (stale_q) begin
						state_q <= ST_SQA;
					end else if (head.valid) begin
						if (head.op == mer_pkg::OP_RESTART) begin
							cur_x_q <= '0;
							cur_y_q <= CW'(b_w);
							gx_q    <= '0;
							state_q <= ST_RS1;
						end else if (region_q != RG_DONE) begin
							cur_x_q <= cur_x_nx;
							cur_y_q <= cur_y_nx;
							gx_q    <= gx_nx;
							gy_q    <= gy_nx;
							dec_q   <= dec_nx;
							beat_q  <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_SQA: state_q <= ST_SQB;
				ST_SQB: state_q <= ST_SQC;
				ST_SQC: state_q <= ST_IDLE;
				ST_RS1: state_q <= ST_RS2;
				ST_RS2: begin
					gy_q     <= gy_rs;
					dec_q    <= (b2_q <<< 2) - (prod_q <<< 2) + a2_q;
					region_q <= RG_ONE;
					state_q  <= rs_in_one ? ST_IDLE : ST_Z1;
				end
				ST_Z1: state_q <= ST_Z2;
				ST_Z2: state_q <= ST_Z3;
				ST_Z3: begin
					dec_q   <= prod_q;
					state_q <= ST_Z4;
				end
				ST_Z4: state_q <= ST_Z5;
				ST_Z5: begin
					dec_q   <= dec_q + (prod_q <<< 2);
					state_q <= ST_Z6;
				end
				ST_Z6: state_q <= ST_Z7;
				ST_Z7: begin
					dec_q    <= dec_q - (prod_q <<< 2);
					region_q <= y_neg ? RG_DONE : RG_TWO;
					state_q  <= ST_IDLE;
				end
				ST_EMIT: begin
					if (beat_done) begin
						beat_q <= beat_q + 2'd1;
						if (beat_q == 2'd3) begin
							if (leave_one) begin
								state_q <= ST_Z1;
							end else begin
								if ((region_q == RG_TWO) && y_neg) begin
									region_q <= RG_DONE;
								end
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_full[DW-1:0];
		if (state_q == ST_SQB) begin
			a2_q <= prod_q;
		end
		if (state_q == ST_SQC) begin
			b2_q <= prod_q;
		end
		if (step_go) begin
			ex_q <= cur_x_q;
			ey_q <= cur_y_q;
		end
	end

endmodule

`default_nettype wire

[rtl/midpoint_ellipse_rasterizer.sv]
// Top level of the midpoint ellipse rasterizer: configuration registers and the three parts.
`default_nettype none

// Each command beat either restarts the walk at (0, b) or advances it by one step that
// emits four mirrored points (x then y mirrored, last_of_step on the fourth). Commands pass
// through a one-entry holding register and a two-deep queue, so the command side keeps
// flowing while points are stalled until both are full. A step updates the decision
// terms, then sends four point beats on the single output channel. A restart passes
// through RS1 and RS2. The switch from region one to region two, and a restart with a
// zero semi-axis, run through Z1 to Z7 on the one shared multiplier, which rebuild the
// region-two decision term. After a write to either semi-axis register the engine
// squares the axes in SQA, SQB and SQC before it takes the next command. Steps after
// the walk has finished, or before the first restart, give no points.
module midpoint_ellipse_rasterizer #(
	parameter int AXIS_BITS     = mer_pkg::AXIS_BITS_DEF,
	parameter int DECISION_BITS = mer_pkg::DECISION_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	mer_cmd_if.sink                                cmd,
	mer_pix_if.source                              pix,
	input  wire logic                              cfg_we,
	input  wire logic [mer_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [mer_pkg::CFG_DATA_W-1:0]    cfg_data
);

	mer_pkg::cfg_t      cfg_q;
	mer_pkg::op_beat_t  push;
	mer_pkg::op_beat_t  head;
	logic               push_ready;
	logic               pop;
	logic               axis_wr;

	assign axis_wr = cfg_we && ((cfg_index == mer_pkg::REG_SEMI_AXIS_X)
		|| (cfg_index == mer_pkg::REG_SEMI_AXIS_Y));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x    <= mer_pkg::CENTER_X_RST;
			cfg_q.center_y    <= mer_pkg::CENTER_Y_RST;
			cfg_q.semi_axis_x <= mer_pkg::SEMI_AXIS_X_RST;
			cfg_q.semi_axis_y <= mer_pkg::SEMI_AXIS_Y_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mer_pkg::REG_CENTER_X:    cfg_q.center_x    <= mer_pkg::CENTER_W'(cfg_data);
				mer_pkg::REG_CENTER_Y:    cfg_q.center_y    <= mer_pkg::CENTER_W'(cfg_data);
				mer_pkg::REG_SEMI_AXIS_X:
					cfg_q.semi_axis_x <= cfg_data[mer_pkg::AXIS_REG_W-1:0];
				mer_pkg::REG_SEMI_AXIS_Y:
					cfg_q.semi_axis_y <= cfg_data[mer_pkg::AXIS_REG_W-1:0];
				default: ;
			endcase
		end
	end

	mer_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push       (push),
		.push_ready (push_ready)
	);

	mer_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	mer_back #(
		.AXIS_BITS     (AXIS_BITS),
		.DECISION_BITS (DECISION_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.axis_wr (axis_wr),
		.head    (head),
		.pop     (pop),
		.pix     (pix)
	);

endmodule

`default_nettype wire

[rtl/mer_checker.sv]
// Assertions on the point channel of the rasterizer, bound to the top level.
`default_nettype none

module mer_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pix_valid,
	input wire logic pix_ready,
	input wire logic pix_last,
	input wire logic pix_done
);

	// The four beats of a step come without gaps on the engine side.
	a_step_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !(pix_ready && pix_last) |=> pix_valid)
		else $error("point beats of one step were interrupted");

	// Whether the walk ends is settled before the first beat of the step.
	a_done_steady: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !(pix_ready && pix_last) |=> $stable(pix_done))
		else $error("ellipse_done changed within a step");

	// The engine leaves the emit state after the last beat of a step, so valid is low in the cycle after it.
	a_gap_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && pix_last |=> !pix_valid)
		else $error("next step emitted without an update cycle");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix.valid),
	.pix_ready (pix.ready),
	.pix_last  (pix.last_of_step),
	.pix_done  (pix.ellipse_done)
);

`default_nettype wire

[test/tb_midpoint_ellipse_rasterizer.sv]
// Self-checking testbench of the midpoint ellipse rasterizer with a built-in walk predictor.
`default_nettype none

module tb_midpoint_ellipse_rasterizer;
	import mer_pkg::*;

	localparam int     AXIS_BITS     = AXIS_BITS_DEF;
	localparam int     DEC_BITS      = DECISION_BITS_DEF;
	localparam int     COORD_W       = AXIS_BITS + 1;
	localparam longint AXIS_MASK     = (longint'(1) << AXIS_BITS) - 1;
	localparam int     SETTLE_CYCLES = 40;
	localparam int     QUIET_LIMIT   = 1000;
	localparam int     RANDOM_ITEMS  = 260;

	typedef enum logic [1:0] {WALK_DONE, WALK_ONE, WALK_TWO} walk_region_e;
	typedef logic signed [DEC_BITS-1:0] term_t;
	typedef logic signed [COORD_W-1:0]  coord_t;

	typedef struct packed {
		logic signed [POINT_W-1:0] x;
		logic signed [POINT_W-1:0] y;
		logic                      last;
		logic                      done;
	} pix_beat_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	mer_cmd_if cmd_ch ();
	mer_pix_if pix_ch ();

	midpoint_ellipse_rasterizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.pix       (pix_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor copy of the configuration and of the walk state.
	cfg_t         model_cfg;
	coord_t       walk_x;
	coord_t       walk_y;
	term_t        walk_d;
	term_t        walk_gx;
	term_t        walk_gy;
	walk_region_e walk_region;

	op_t       pending_cmds[$];
	pix_beat_t expected_points[$];

	int mismatches = 0;
	int quiet_cycles = 0;
	int tx_gap = 0;
	int rx_stall = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit cmd_taken = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	// Region one ends once the x gradient catches up with the y gradient; the
	// region-two decision term is rebuilt from the current point at that moment.
	function automatic void enter_next_region(longint a2, longint b2);
		longint tx, ty, acc;
		if (walk_region == WALK_ONE && !(walk_gx < walk_gy)) begin
			tx = 2 * longint'(walk_x) + 1;
			ty = longint'(walk_y) - 1;
			acc = b2 * tx * tx + 4 * a2 * ty * ty - 4 * a2 * b2;
			walk_d = acc[DEC_BITS-1:0];
			walk_region = WALK_TWO;
		end
		if (walk_region == WALK_TWO && walk_y < 0)
			walk_region = WALK_DONE;
	endfunction

	function automatic void advance_walk(op_t op);
		longint a, b, a2, b2, cx, cy, acc;
		longint px[4];
		longint py[4];
		pix_beat_t beat;
		a = longint'(model_cfg.semi_axis_x) & AXIS_MASK;
		b = longint'(model_cfg.semi_axis_y) & AXIS_MASK;
		a2 = a * a;
		b2 = b * b;
		cx = longint'($signed(model_cfg.center_x));
		cy = longint'($signed(model_cfg.center_y));
		if (op == OP_RESTART) begin
			walk_x = '0;
			walk_y = b[COORD_W-1:0];
			acc = 4 * b2 - 4 * a2 * b + a2;
			walk_d = acc[DEC_BITS-1:0];
			walk_gx = '0;
			acc = 2 * a2 * b;
			walk_gy = acc[DEC_BITS-1:0];
			walk_region = WALK_ONE;
			enter_next_region(a2, b2);
			return;
		end
		if (walk_region == WALK_DONE)
			return;

		px[0] = cx + longint'(walk_x); py[0] = cy + longint'(walk_y);
		px[1] = cx - longint'(walk_x); py[1] = cy + longint'(walk_y);
		px[2] = cx + longint'(walk_x); py[2] = cy - longint'(walk_y);
		px[3] = cx - longint'(walk_x); py[3] = cy - longint'(walk_y);

		if (walk_region == WALK_ONE) begin
			walk_x = walk_x + coord_t'(1);
			acc = longint'(walk_gx) + 2 * b2;
			walk_gx = acc[DEC_BITS-1:0];
			if (walk_d < 0) begin
				acc = longint'(walk_d) + 4 * longint'(walk_gx) + 4 * b2;
			end else begin
				walk_y = walk_y - coord_t'(1);
				acc = longint'(walk_gy) - 2 * a2;
				walk_gy = acc[DEC_BITS-1:0];
				acc = longint'(walk_d) + 4 * longint'(walk_gx) - 4 * longint'(walk_gy) + 4 * b2;
			end
			walk_d = acc[DEC_BITS-1:0];
		end else begin
			walk_y = walk_y - coord_t'(1);
			acc = longint'(walk_gy) - 2 * a2;
			walk_gy = acc[DEC_BITS-1:0];
			if (walk_d > 0) begin
				acc = longint'(walk_d) + 4 * a2 - 4 * longint'(walk_gy);
			end else begin
				walk_x = walk_x + coord_t'(1);
				acc = longint'(walk_gx) + 2 * b2;
				walk_gx = acc[DEC_BITS-1:0];
				acc = longint'(walk_d) + 4 * longint'(walk_gx) - 4 * longint'(walk_gy) + 4 * a2;
			end
			walk_d = acc[DEC_BITS-1:0];
		end
		enter_next_region(a2, b2);

		for (int k = 0; k < 4; k++) begin
			beat.x = px[k][POINT_W-1:0];
			beat.y = py[k][POINT_W-1:0];
			beat.last = (k == 3);
			beat.done = (walk_region == WALK_DONE);
			expected_points.push_back(beat);
		end
	endfunction

	// Command driver: a new beat is presented only once the previous one was taken.
	always @(negedge clk) begin
		if (!cmd_ch.valid || cmd_taken) begin
			cmd_taken = 1'b0;
			if (tx_gap > 0) begin
				tx_gap--;
				cmd_ch.valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cmd_ch.valid <= 1'b1;
				cmd_ch.restart <= pending_cmds.pop_front();
				tx_gap = pick_gap(tx_calm);
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Point sink with random back-pressure.
	always @(negedge clk) begin
		if (rx_stall > 0) begin
			rx_stall--;
			pix_ch.ready <= 1'b0;
		end else begin
			pix_ch.ready <= 1'b1;
			rx_stall = pick_gap(rx_calm);
		end
	end

	always @(posedge clk) begin : monitor
		pix_beat_t want;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				cmd_taken = 1'b1;
				advance_walk(cmd_ch.restart);
			end
			if (pix_ch.valid && pix_ch.ready) begin
				if (expected_points.size() == 0) begin
					$error("point beat (%0d, %0d) arrived with no point expected",
						pix_ch.point_x, pix_ch.point_y);
					mismatches++;
				end else begin
					want = expected_points.pop_front();
					if (pix_ch.point_x !== want.x) begin
						$error("point_x: expected %0d, got %0d", want.x, pix_ch.point_x);
						mismatches++;
					end
					if (pix_ch.point_y !== want.y) begin
						$error("point_y: expected %0d, got %0d", want.y, pix_ch.point_y);
						mismatches++;
					end
					if (pix_ch.last_of_step !== want.last) begin
						$error("last_of_step: expected %0b, got %0b", want.last,
							pix_ch.last_of_step);
						mismatches++;
					end
					if (pix_ch.ellipse_done !== want.done) begin
						$error("ellipse_done: expected %0b, got %0b", want.done,
							pix_ch.ellipse_done);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_midpoint_ellipse_rasterizer failed");
			$finish;
		end
	end

	task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_CENTER_X: model_cfg.center_x = data;
			REG_CENTER_Y: model_cfg.center_y = data;
			REG_SEMI_AXIS_X: model_cfg.semi_axis_x = data[AXIS_REG_W-1:0];
			REG_SEMI_AXIS_Y: model_cfg.semi_axis_y = data[AXIS_REG_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Restarts and finished steps give no points, so a fixed pause follows the last point.
	task automatic wait_idle();
		while (pending_cmds.size() != 0 || cmd_ch.valid || expected_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int random_items;
		int a_sel;
		int b_sel;
		int n_steps;
		bit big;
		bit skip_restart;
		int phase;

		cmd_ch.valid = 1'b0;
		cmd_ch.restart = OP_STEP;
		pix_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		model_cfg = '{CENTER_X_RST, CENTER_Y_RST, SEMI_AXIS_X_RST, SEMI_AXIS_Y_RST};
		walk_x = '0;
		walk_y = '1;
		walk_d = '0;
		walk_gx = '0;
		walk_gy = '0;
		walk_region = WALK_DONE;

		arst_n = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// A step before any restart, then a full walk on the reset settings and
		// three steps past its end.
		pending_cmds.push_back(OP_STEP);
		pending_cmds.push_back(OP_RESTART);
		repeat (12) pending_cmds.push_back(OP_STEP);
		wait_idle();

		// Writes to unused indexes, extreme centres and a zero x semi-axis.
		for (int i = 4; i < 8; i++)
			set_reg(CFG_INDEX_W'(i), CFG_DATA_W'($urandom_range(0, 4095)));
		set_reg(REG_CENTER_X, 12'h800);
		set_reg(REG_CENTER_Y, 12'h7FF);
		set_reg(REG_SEMI_AXIS_X, 12'h000);
		set_reg(REG_SEMI_AXIS_Y, 12'h003);
		pending_cmds.push_back(OP_RESTART);
		repeat (5) pending_cmds.push_back(OP_STEP);
		wait_idle();

		// Largest axes; the upper data bit is dropped by the axis registers.
		set_reg(REG_CENTER_X, 12'h7FF);
		set_reg(REG_CENTER_Y, 12'h800);
		set_reg(REG_SEMI_AXIS_X, 12'hFFF);
		set_reg(REG_SEMI_AXIS_Y, 12'hFFF);
		pending_cmds.push_back(OP_RESTART);
		repeat (4) pending_cmds.push_back(OP_STEP);
		wait_idle();

		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			big = ($urandom_range(0, 9) == 0);
			if (big) begin
				a_sel = $urandom_range(0, 2047);
				b_sel = $urandom_range(0, 2047);
				n_steps = $urandom_range(2, 6);
			end else begin
				a_sel = $urandom_range(0, 10);
				b_sel = $urandom_range(0, 10);
				n_steps = $urandom_range(1, a_sel + b_sel + 3);
			end
			if ($urandom_range(0, 1))
				set_reg(REG_CENTER_X, CFG_DATA_W'($urandom_range(0, 4095)));
			if ($urandom_range(0, 1))
				set_reg(REG_CENTER_Y, CFG_DATA_W'($urandom_range(0, 4095)));
			set_reg(REG_SEMI_AXIS_X, {1'($urandom_range(0, 1)), 11'(a_sel)});
			set_reg(REG_SEMI_AXIS_Y, {1'($urandom_range(0, 1)), 11'(b_sel)});
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);

			// The first phase carries on with the unfinished large walk under new settings.
			skip_restart = (phase == 0) || ($urandom_range(0, 5) == 0);
			if (!skip_restart) begin
				pending_cmds.push_back(OP_RESTART);
				random_items++;
			end
			for (int i = 0; i < n_steps; i++) begin
				if ($urandom_range(0, 11) == 0)
					pending_cmds.push_back($urandom_range(0, 1) ? OP_RESTART : OP_STEP);
				else
					pending_cmds.push_back(OP_STEP);
				random_items++;
			end
			wait_idle();
			phase++;
		end

		if (mismatches == 0 && expected_points.size() == 0)
			$display("tb_midpoint_ellipse_rasterizer passed");
		else
			$display("tb_midpoint_ellipse_rasterizer failed");
		$finish;
	end
endmodule

`default_nettype wire
